### rtl/gtrq_pkg.sv
// Types, constants and the control store for the gray tone range quantizer.
// Depends on nothing; used by every module of the block.
package gtrq_pkg;

	localparam int PIX_W   = 8;
	localparam int TONE_W  = 9;
	localparam int RANGE_W = 10;
	localparam int DIVD_W  = 18;
	localparam int DIVS_W  = 10;
	localparam int ITER    = DIVD_W / 2;
	localparam int CNT_W   = 4;
	localparam int PC_W    = 4;
	localparam int ALPHA_W = 10;
	localparam int QSUM_W  = 19;

	localparam logic [TONE_W-1:0] TONE_RESET = 9'd256;
	localparam logic [PIX_W-1:0]  MIN_RESET  = 8'd255;
	localparam logic [PIX_W-1:0]  MAX_RESET  = 8'd0;

	// Item operation codes
	localparam logic OP_SCAN = 1'b0;
	localparam logic OP_MAP  = 1'b1;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_RANGE,
		DP_LOAD1,
		DP_STEP,
		DP_ALPHA,
		DP_LOAD2,
		DP_EMIT_Q,
		DP_EMIT_P,
		DP_SCAN
	} dp_op_t;

	typedef enum logic [1:0] {
		JMP_NONE,
		JMP_SCAN,
		JMP_NOT_LESS,
		JMP_NOT_LAST
	} jmp_t;

	typedef struct packed {
		dp_op_t           op;
		jmp_t             jmp;
		logic [PC_W-1:0]  target;
		logic             last;
	} ctrl_word_t;

	typedef struct packed {
		logic is_scan;
		logic not_less;
		logic div_last;
	} status_t;

	localparam logic [PC_W-1:0] A_ENTRY = 4'd0;
	localparam logic [PC_W-1:0] A_TEST  = 4'd1;
	localparam logic [PC_W-1:0] A_LOAD1 = 4'd2;
	localparam logic [PC_W-1:0] A_DIV1  = 4'd3;
	localparam logic [PC_W-1:0] A_ALPHA = 4'd4;
	localparam logic [PC_W-1:0] A_LOAD2 = 4'd5;
	localparam logic [PC_W-1:0] A_DIV2  = 4'd6;
	localparam logic [PC_W-1:0] A_EMITQ = 4'd7;
	localparam logic [PC_W-1:0] A_PASS  = 4'd8;
	localparam logic [PC_W-1:0] A_SCAN  = 4'd9;

	localparam ctrl_word_t IDLE_WORD = '{op: DP_NOP, jmp: JMP_NONE, target: A_ENTRY, last: 1'b0};

	// Microprogram: one control word per step
	function automatic ctrl_word_t rom_word(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		w = IDLE_WORD;
		unique case (pc)
			A_ENTRY: w = '{op: DP_RANGE,  jmp: JMP_SCAN,     target: A_SCAN,  last: 1'b0};
			A_TEST:  w = '{op: DP_NOP,    jmp: JMP_NOT_LESS, target: A_PASS,  last: 1'b0};
			A_LOAD1: w = '{op: DP_LOAD1,  jmp: JMP_NONE,     target: A_ENTRY, last: 1'b0};
			A_DIV1:  w = '{op: DP_STEP,   jmp: JMP_NOT_LAST, target: A_DIV1,  last: 1'b0};
			A_ALPHA: w = '{op: DP_ALPHA,  jmp: JMP_NONE,     target: A_ENTRY, last: 1'b0};
			A_LOAD2: w = '{op: DP_LOAD2,  jmp: JMP_NONE,     target: A_ENTRY, last: 1'b0};
			A_DIV2:  w = '{op: DP_STEP,   jmp: JMP_NOT_LAST, target: A_DIV2,  last: 1'b0};
			A_EMITQ: w = '{op: DP_EMIT_Q, jmp: JMP_NONE,     target: A_ENTRY, last: 1'b1};
			A_PASS:  w = '{op: DP_EMIT_P, jmp: JMP_NONE,     target: A_ENTRY, last: 1'b1};
			A_SCAN:  w = '{op: DP_SCAN,   jmp: JMP_NONE,     target: A_ENTRY, last: 1'b1};
			default: w = '{op: DP_NOP,    jmp: JMP_NONE,     target: A_ENTRY, last: 1'b1};
		endcase
		return w;
	endfunction

endpackage

### rtl/gtrq_divider.sv
// Unsigned restoring divider, two quotient bits per cycle while step is asserted.
// Depends on gtrq_pkg for widths and the iteration count.
module gtrq_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           load,
	input  logic                           step,
	input  logic [gtrq_pkg::DIVD_W-1:0]    dividend,
	input  logic [gtrq_pkg::DIVS_W-1:0]    divisor,
	output logic [gtrq_pkg::DIVD_W-1:0]    quot,
	output logic                           rem_nz,
	output logic                           last
);

	logic [gtrq_pkg::DIVD_W-1:0] acc_q;
	logic [gtrq_pkg::DIVS_W-1:0] rem_q;
	logic [gtrq_pkg::DIVS_W-1:0] div_q;
	logic [gtrq_pkg::CNT_W-1:0]  cnt_q;

	logic [gtrq_pkg::DIVS_W:0]   r1, r2, d1, d2;
	logic                        ge1, ge2;
	logic [gtrq_pkg::DIVS_W-1:0] r1s, r2s;

	always_comb begin
		r1  = {rem_q, acc_q[gtrq_pkg::DIVD_W-1]};
		d1  = r1 - {1'b0, div_q};
		ge1 = r1 >= {1'b0, div_q};
		r1s = ge1 ? d1[gtrq_pkg::DIVS_W-1:0] : r1[gtrq_pkg::DIVS_W-1:0];
		r2  = {r1s, acc_q[gtrq_pkg::DIVD_W-2]};
		d2  = r2 - {1'b0, div_q};
		ge2 = r2 >= {1'b0, div_q};
		r2s = ge2 ? d2[gtrq_pkg::DIVS_W-1:0] : r2[gtrq_pkg::DIVS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			acc_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (step) begin
			acc_q <= {acc_q[gtrq_pkg::DIVD_W-3:0], ge1, ge2};
			rem_q <= r2s;
		end
	end

	assign quot   = acc_q;
	assign rem_nz = rem_q != '0;
	assign last   = cnt_q == gtrq_pkg::CNT_W'(gtrq_pkg::ITER - 1);

endmodule

### rtl/gtrq_sequencer.sv
// Step counter and control store: issues one control word per cycle.
// Depends on gtrq_pkg for the microprogram and the control types.
module gtrq_sequencer (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  gtrq_pkg::status_t     status,
	output gtrq_pkg::ctrl_word_t  ctrl,
	output logic                  busy
);

	logic [gtrq_pkg::PC_W-1:0] pc_q;
	logic                      busy_q;
	gtrq_pkg::ctrl_word_t      word;
	logic                      taken;

	always_comb begin
		word  = gtrq_pkg::rom_word(pc_q);
		taken = 1'b0;
		unique case (word.jmp)
			gtrq_pkg::JMP_NONE:     taken = 1'b0;
			gtrq_pkg::JMP_SCAN:     taken = status.is_scan;
			gtrq_pkg::JMP_NOT_LESS: taken = status.not_less;
			gtrq_pkg::JMP_NOT_LAST: taken = !status.div_last;
			default:                taken = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= gtrq_pkg::A_ENTRY;
			busy_q <= 1'b0;
		end else if (accept) begin
			pc_q   <= gtrq_pkg::A_ENTRY;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			if (word.last) begin
				pc_q   <= gtrq_pkg::A_ENTRY;
				busy_q <= 1'b0;
			end else begin
				pc_q <= taken ? word.target : pc_q + 1'b1;
			end
		end
	end

	assign ctrl = busy_q ? word : gtrq_pkg::IDLE_WORD;
	assign busy = busy_q;

	// Idle sequencer parks at the entry step
	a_idle_parked: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> pc_q == gtrq_pkg::A_ENTRY)
		else $error("sequencer idle away from entry step");

	a_pc_in_program: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> pc_q <= gtrq_pkg::A_SCAN)
		else $error("step counter left the program");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && word.last && !accept) |=> !busy_q)
		else $error("program did not end on its last word");

endmodule

### rtl/gray_tone_range_quantizer.sv
// Gray tone range quantizer top level: datapath registers and arithmetic.
// Depends on gtrq_pkg, gtrq_sequencer and gtrq_divider.
// A map item shows its result after two divisions on the shared divider when it is
// quantized, and without any division when it passes through.
// A scan item gives no result; start may follow in the cycle done shows.
// Reset: tone_count 256, minimum 255, maximum 0, sequencer idle; results cannot be stalled.
module gray_tone_range_quantizer (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         operation,
	input  logic                         first_of_frame,
	input  logic [gtrq_pkg::PIX_W-1:0]   pixel_value,
	input  logic                         cfg_we,
	input  logic [gtrq_pkg::TONE_W-1:0]  cfg_wdata,
	output logic                         done,
	output logic [gtrq_pkg::PIX_W-1:0]   quant_tone
);

	gtrq_pkg::ctrl_word_t ctrl;
	gtrq_pkg::status_t    status;
	logic                 accept;

	logic                                op_q, first_q;
	logic [gtrq_pkg::PIX_W-1:0]          pix_q;
	logic [gtrq_pkg::TONE_W-1:0]         tone_q;
	logic [gtrq_pkg::PIX_W-1:0]          min_q, max_q;
	logic signed [gtrq_pkg::RANGE_W-1:0] range_q;
	logic                                neg1_q, neg2_q;
	logic signed [gtrq_pkg::ALPHA_W-1:0] alpha_q;
	logic [gtrq_pkg::PIX_W-1:0]          quant_q;
	logic                                done_q;

	logic [gtrq_pkg::DIVD_W-1:0]         quot;
	logic                                rem_nz, div_last;
	logic [gtrq_pkg::DIVD_W-1:0]         dividend;
	logic [gtrq_pkg::DIVS_W-1:0]         divisor;
	logic                                div_load;

	logic [gtrq_pkg::TONE_W-1:0]         n_eff;
	logic signed [8:0]                   diff;
	logic signed [9:0]                   t1;
	logic [8:0]                          mag1;
	logic signed [10:0]                  t2;
	logic [10:0]                         mag2;
	logic [9:0]                          a_mag;
	logic [gtrq_pkg::DIVD_W-1:0]         f_mag;
	logic signed [gtrq_pkg::QSUM_W-1:0]  f_val, q_sum;
	logic [gtrq_pkg::PIX_W-1:0]          q_sat;
	logic [gtrq_pkg::PIX_W-1:0]          base_min, base_max;

	assign accept = start && !busy;

	gtrq_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.status (status),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	always_comb begin
		// a zero tone count acts as one
		n_eff = (tone_q == '0) ? 9'd1 : tone_q;

		diff = $signed({1'b0, pix_q}) - $signed({1'b0, min_q});
		t1   = {diff, 1'b1};
		mag1 = t1[9] ? 9'(-t1) : t1[8:0];

		t2   = {alpha_q, 1'b1};
		mag2 = t2[10] ? 11'(-t2) : 11'(t2);

		a_mag = quot[9:0] + {9'd0, neg1_q & rem_nz};
		f_mag = quot + {{(gtrq_pkg::DIVD_W-1){1'b0}}, neg2_q & rem_nz};
		f_val = neg2_q ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});
		q_sum = $signed({{(gtrq_pkg::QSUM_W-gtrq_pkg::PIX_W){1'b0}}, min_q}) + f_val;
		if (q_sum < 0) begin
			q_sat = 8'd0;
		end else if (q_sum > 19'sd255) begin
			q_sat = 8'd255;
		end else begin
			q_sat = q_sum[7:0];
		end

		base_min = first_q ? gtrq_pkg::MIN_RESET : min_q;
		base_max = first_q ? gtrq_pkg::MAX_RESET : max_q;

		// n is below the range here, so it fits in eight bits
		div_load = 1'b0;
		dividend = '0;
		divisor  = '0;
		case (ctrl.op)
			gtrq_pkg::DP_LOAD1: begin
				div_load = 1'b1;
				dividend = gtrq_pkg::DIVD_W'(mag1 * n_eff[7:0]);
				divisor  = {range_q[8:0], 1'b0};
			end
			gtrq_pkg::DP_LOAD2: begin
				div_load = 1'b1;
				dividend = gtrq_pkg::DIVD_W'(mag2[8:0] * range_q[8:0]);
				divisor  = {n_eff, 1'b0};
			end
			default: begin
				div_load = 1'b0;
			end
		endcase

		status.is_scan  = (op_q == gtrq_pkg::OP_SCAN);
		status.not_less = !($signed({1'b0, n_eff}) < range_q);
		status.div_last = div_last;
	end

	gtrq_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (div_load),
		.step     (ctrl.op == gtrq_pkg::DP_STEP),
		.dividend (dividend),
		.divisor  (divisor),
		.quot     (quot),
		.rem_nz   (rem_nz),
		.last     (div_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tone_q <= gtrq_pkg::TONE_RESET;
			min_q  <= gtrq_pkg::MIN_RESET;
			max_q  <= gtrq_pkg::MAX_RESET;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tone_q <= cfg_wdata;
			end
			case (ctrl.op) inside
				gtrq_pkg::DP_SCAN: begin
					min_q  <= (pix_q < base_min) ? pix_q : base_min;
					max_q  <= (pix_q > base_max) ? pix_q : base_max;
					done_q <= 1'b0;
				end
				gtrq_pkg::DP_EMIT_Q, gtrq_pkg::DP_EMIT_P: begin
					done_q <= 1'b1;
				end
				default: begin
					done_q <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			first_q <= first_of_frame;
			pix_q   <= pixel_value;
		end
		case (ctrl.op)
			gtrq_pkg::DP_RANGE: begin
				range_q <= $signed({2'b00, max_q}) - $signed({2'b00, min_q}) + 10'sd1;
			end
			gtrq_pkg::DP_LOAD1: begin
				neg1_q <= t1[9];
			end
			gtrq_pkg::DP_ALPHA: begin
				// floor of a negative quotient rounds away from zero
				alpha_q <= neg1_q ? -$signed(a_mag) : $signed(a_mag);
			end
			gtrq_pkg::DP_LOAD2: begin
				neg2_q <= alpha_q[gtrq_pkg::ALPHA_W-1];
			end
			gtrq_pkg::DP_EMIT_Q: begin
				quant_q <= q_sat;
			end
			gtrq_pkg::DP_EMIT_P: begin
				quant_q <= pix_q;
			end
			default: begin
				quant_q <= quant_q;
			end
		endcase
	end

	assign done       = done_q;
	assign quant_tone = quant_q;

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy && $past(busy))
		else $error("result strobe without a finished item");

	a_scan_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && op_q == gtrq_pkg::OP_SCAN) |=> !done)
		else $error("scan item produced a result");

	a_start_takes: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("start transfer not taken up");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		$past(ctrl.op == gtrq_pkg::DP_SCAN) |-> min_q <= max_q)
		else $error("tone range inverted after a scan");

endmodule
